// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL; clocked on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define HSC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define HSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_W     = 12;
    localparam int IDX_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_B_RD  = 9'b000000010,
        ST_B_V   = 9'b000000100,
        ST_X_RD  = 9'b000001000,
        ST_X_SW  = 9'b000010000,
        ST_S_RD  = 9'b000100000,
        ST_S_CMP = 9'b001000000,
        ST_O_RD  = 9'b010000000,
        ST_O_LD  = 9'b100000000
    } t_state;

    // one-based heap index to zero-based memory address
    function automatic logic [ADDR_W-1:0] idx_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] t;
        t = idx - 1'b1;
        return t[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/heap_sort_with_call_count.sv =====
// Load: one item per cycle into the heap memory; the set closes on tlast or at capacity.
// Sort: a sift level reads both children (S_RD), then compares and writes the node (S_CMP); build
//   nodes are read first (B_RD, B_V), extractions swap root and last (X_RD, X_SW); input held off.
// Output: each result is read from the memory's registered read port (O_RD) and loaded (O_LD)
//   into the output register once the previous result has been taken.
// Reset (synchronous, active low) clears control, counters and the output valid only.
`default_nettype none

module heap_sort_with_call_count (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire  [hsc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [31:0] value
    input  wire                              i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic [hsc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,  // [31:0] value_res, [43:32] call_count
    output logic                             o_m_axis_tlast
);

`include "assert_macros.svh"

    localparam int DW = hsc_pkg::DATA_WIDTH;
    localparam int IW = hsc_pkg::IDX_W;
    localparam int AW = hsc_pkg::ADDR_W;
    localparam int CW = hsc_pkg::COUNT_W;

    logic [DW-1:0] r_mem [hsc_pkg::CAPACITY];

    hsc_pkg::t_state r_state, n_state;

    logic [IW-1:0]        r_cnt, r_size, r_i, r_node;
    logic [AW-1:0]        r_k;
    logic                 r_build;
    logic signed [DW-1:0] r_v, r_rd_a, r_rd_b;
    logic [CW-1:0]        r_calls;
    logic                 r_ovalid, r_olast;
    logic [DW-1:0]        r_odata;
    logic [CW-1:0]        r_ocount;

    logic          s_acc, o_acc;
    logic [IW-1:0] cnt_inc;
    logic [IW:0]   left, right, left_m1;
    logic          l_gt, r_gt;
    logic signed [DW-1:0] big_val;
    logic          out_last;

    logic          w_en;
    logic [AW-1:0] w_addr, a_addr, b_addr;
    logic [DW-1:0] w_data;

    assign o_s_axis_tready = (r_state == hsc_pkg::ST_LOAD);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_acc           = r_ovalid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = hsc_pkg::OUT_TDATA_W'({r_ocount, r_odata});

    assign cnt_inc = r_cnt + 1'b1;
    assign left    = {r_node, 1'b0};
    assign right   = left + 1'b1;
    assign left_m1 = left - 1'b1;

    // child compare: left first, right must beat the larger of node and left
    always_comb begin
        l_gt    = (left <= {1'b0, r_size}) && (r_rd_a > r_v);
        big_val = l_gt ? r_rd_a : r_v;
        r_gt    = (right <= {1'b0, r_size}) && (r_rd_b > big_val);
    end

    assign out_last = ({1'b0, r_k} + 1'b1) == r_cnt;

    // memory port control
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cnt[AW-1:0];
        w_data = i_s_axis_tdata[DW-1:0];
        a_addr = r_k;
        b_addr = '0;
        case (r_state)
            hsc_pkg::ST_LOAD: begin
                w_en = s_acc;
            end
            hsc_pkg::ST_B_RD: begin
                a_addr = hsc_pkg::idx_addr(r_i);
            end
            hsc_pkg::ST_X_RD: begin
                a_addr = '0;
                b_addr = hsc_pkg::idx_addr(r_size);
            end
            hsc_pkg::ST_X_SW: begin
                w_en   = 1'b1;
                w_addr = hsc_pkg::idx_addr(r_size);
                w_data = r_rd_a;
            end
            hsc_pkg::ST_S_RD: begin
                a_addr = left_m1[AW-1:0];
                b_addr = left[AW-1:0];
            end
            hsc_pkg::ST_S_CMP: begin
                w_en   = 1'b1;
                w_addr = hsc_pkg::idx_addr(r_node);
                w_data = r_gt ? r_rd_b : (l_gt ? r_rd_a : r_v);
            end
            default: begin
                a_addr = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_a <= r_mem[a_addr];
        r_rd_b <= r_mem[b_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hsc_pkg::ST_LOAD: begin
                if (s_acc && (i_s_axis_tlast || r_cnt == IW'(hsc_pkg::CAPACITY - 1))) begin
                    n_state = hsc_pkg::ST_B_RD;
                end
            end
            hsc_pkg::ST_B_RD: begin
                n_state = (r_i == '0) ? hsc_pkg::ST_X_RD : hsc_pkg::ST_B_V;
            end
            hsc_pkg::ST_B_V:  n_state = hsc_pkg::ST_S_RD;
            hsc_pkg::ST_X_RD: begin
                n_state = (r_size == '0) ? hsc_pkg::ST_O_RD : hsc_pkg::ST_X_SW;
            end
            hsc_pkg::ST_X_SW: begin
                n_state = (r_size == IW'(1)) ? hsc_pkg::ST_X_RD : hsc_pkg::ST_S_RD;
            end
            hsc_pkg::ST_S_RD: n_state = hsc_pkg::ST_S_CMP;
            hsc_pkg::ST_S_CMP: begin
                if (l_gt || r_gt) begin
                    n_state = hsc_pkg::ST_S_RD;
                end else begin
                    n_state = r_build ? hsc_pkg::ST_B_RD : hsc_pkg::ST_X_RD;
                end
            end
            hsc_pkg::ST_O_RD: n_state = hsc_pkg::ST_O_LD;
            hsc_pkg::ST_O_LD: begin
                if (!r_ovalid || o_acc) begin
                    n_state = out_last ? hsc_pkg::ST_LOAD : hsc_pkg::ST_O_RD;
                end
            end
            default: n_state = hsc_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsc_pkg::ST_LOAD;
            r_cnt    <= '0;
            r_calls  <= '0;
            r_ovalid <= 1'b0;
            r_build  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_acc && r_state != hsc_pkg::ST_O_LD) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                hsc_pkg::ST_LOAD: begin
                    if (s_acc) begin
                        r_cnt  <= cnt_inc;
                        r_size <= cnt_inc;
                        r_i    <= cnt_inc >> 1;
                        r_calls <= '0;
                        r_k    <= '0;
                    end
                end
                hsc_pkg::ST_B_V: begin
                    r_v     <= r_rd_a;
                    r_node  <= r_i;
                    r_build <= 1'b1;
                end
                hsc_pkg::ST_X_SW: begin
                    r_v     <= r_rd_b;
                    r_node  <= IW'(1);
                    r_size  <= r_size - 1'b1;
                    r_build <= 1'b0;
                end
                hsc_pkg::ST_S_CMP: begin
                    if (r_calls != hsc_pkg::COUNT_MAX) begin
                        r_calls <= r_calls + 1'b1;
                    end
                    if (r_gt) begin
                        r_node <= right[IW-1:0];
                    end else if (l_gt) begin
                        r_node <= left[IW-1:0];
                    end else if (r_build) begin
                        r_i <= r_i - 1'b1;
                    end
                end
                hsc_pkg::ST_O_LD: begin
                    if (!r_ovalid || o_acc) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_rd_a;
                        r_olast  <= out_last;
                        r_ocount <= out_last ? r_calls : '0;
                        if (out_last) begin
                            r_cnt <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    `HSC_ASSERT(a_node_in_heap,
        r_state != hsc_pkg::ST_S_CMP || (r_node != '0 && r_node <= r_size),
        "sift node outside heap")
    `HSC_ASSERT(a_swap_nonempty, r_state != hsc_pkg::ST_X_SW || r_size != '0,
        "swap on empty heap")
    `HSC_ASSERT_NEXT(a_count_step, r_state == hsc_pkg::ST_S_CMP,
        r_calls == $past(r_calls) + 1'b1 || r_calls == hsc_pkg::COUNT_MAX,
        "sift step not counted")
    `HSC_ASSERT(a_count_only_last, !r_ovalid || r_olast || r_ocount == '0,
        "count on non-final item")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [hsc_pkg::DATA_WIDTH-1:0] value;
        logic [hsc_pkg::COUNT_W-1:0]           count;
        logic                                  last;
    } t_sorted;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [hsc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata = '0;   // [31:0] value
    logic                             i_s_axis_tlast = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [hsc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;  // [31:0] value_res, [43:32] call_count
    logic                             o_m_axis_tlast;

    heap_sort_with_call_count u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predictor state
    logic signed [hsc_pkg::DATA_WIDTH-1:0] set_vals [$];
    logic signed [hsc_pkg::DATA_WIDTH-1:0] heap_mem [1:hsc_pkg::CAPACITY];
    logic [hsc_pkg::COUNT_W-1:0]           sift_calls;
    t_sorted                               sorted_q [$];
    t_sorted                               want;

    int  errors = 0;
    int  items_sent = 0;
    int  sets_closed = 0;
    int  results_seen = 0;
    int  hold_req = 0;
    bit  quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void sift_node(int node, int size);
        int left;
        int right;
        int big;
        logic signed [hsc_pkg::DATA_WIDTH-1:0] t;
        forever begin
            if (size >= 1 && sift_calls != hsc_pkg::COUNT_MAX)
                sift_calls++;
            left = node * 2;
            right = left + 1;
            big = node;
            if (left <= size && heap_mem[left] > heap_mem[big])
                big = left;
            if (right <= size && heap_mem[right] > heap_mem[big])
                big = right;
            if (big == node)
                return;
            t = heap_mem[big];
            heap_mem[big] = heap_mem[node];
            heap_mem[node] = t;
            node = big;
        end
    endfunction

    function automatic void heapsort_set();
        int n;
        int size;
        t_sorted r;
        logic signed [hsc_pkg::DATA_WIDTH-1:0] t;
        n = set_vals.size();
        for (int i = 1; i <= n; i++)
            heap_mem[i] = set_vals[i-1];
        sift_calls = '0;
        for (int i = n / 2; i > 0; i--)
            sift_node(i, n);
        size = n;
        for (int i = 1; i <= n; i++) begin
            t = heap_mem[size];
            heap_mem[size] = heap_mem[1];
            heap_mem[1] = t;
            size--;
            sift_node(1, size);
        end
        for (int k = 1; k <= n; k++) begin
            r.value = heap_mem[k];
            r.count = (k == n) ? sift_calls : '0;
            r.last  = (k == n);
            sorted_q.push_back(r);
        end
        set_vals.delete();
        sets_closed++;
    endfunction

    function automatic logic signed [hsc_pkg::DATA_WIDTH-1:0] rand_value();
        int t;
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: begin
                t = $urandom_range(0, 8);
                return t - 4;
            end
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge; tvalid stays high for the next item
    task automatic send_item(input logic signed [hsc_pkg::DATA_WIDTH-1:0] v, input logic l);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= $unsigned(v);
        i_s_axis_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        set_vals.push_back(v);
        if (l || set_vals.size() == hsc_pkg::CAPACITY)
            heapsort_set();
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_set(input int n);
        for (int i = 1; i <= n; i++)
            send_item(rand_value(), i == n);
    endtask

    task automatic test_directed();
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_item(5, i == 3);
        for (int i = 3; i >= 1; i--)
            send_item(i, i == 1);
        for (int i = 1; i <= 5; i++)
            send_item(i, i == 5);
        stop_sending();
    endtask

    // full store closes the set without tlast
    task automatic test_store_full();
        for (int i = 0; i < hsc_pkg::CAPACITY; i++)
            send_item(rand_value(), 1'b0);
        stop_sending();
    endtask

    task automatic test_random();
        while (items_sent < 92)
            send_set($urandom_range(1, 8));
        stop_sending();
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        for (int s = 0; s < 2; s++)
            send_set(4);
        stop_sending();
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        send_set(3);
        send_set(1);
        send_set(4);
        stop_sending();
    endtask

    // receiver: random stall bursts, long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected item value=%0d count=%0d last=%0b", $realtime,
                         $signed(o_m_axis_tdata[hsc_pkg::DATA_WIDTH-1:0]),
                         o_m_axis_tdata[hsc_pkg::DATA_WIDTH +: hsc_pkg::COUNT_W],
                         o_m_axis_tlast);
                errors++;
            end else begin
                want = sorted_q.pop_front();
                if (o_m_axis_tdata[hsc_pkg::DATA_WIDTH-1:0] !== want.value) begin
                    $display("%0t: value expected %0d actual %0d", $realtime, want.value,
                             $signed(o_m_axis_tdata[hsc_pkg::DATA_WIDTH-1:0]));
                    errors++;
                end
                if (o_m_axis_tdata[hsc_pkg::DATA_WIDTH +: hsc_pkg::COUNT_W] !== want.count) begin
                    $display("%0t: call_count expected %0d actual %0d", $realtime, want.count,
                             o_m_axis_tdata[hsc_pkg::DATA_WIDTH +: hsc_pkg::COUNT_W]);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $realtime, want.last,
                             o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_store_full();
        test_random();
        test_backpressure();
        test_no_idle();
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sorted_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, sorted_q.size());
            errors++;
        end
        $display("sorted %0d sets from %0d items, %0d results checked", sets_closed,
                 items_sent, results_seen);
        $display("incl. extremes, duplicates, capacity close, long output hold-off");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/hsc_pkg.sv
design/heap_sort_with_call_count.sv
bench/tb.sv
